FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker file of the pulse width scaler.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define PWAS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define PWAS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/pwas_pkg.sv
// Shared types and constants of the pulse width autorange scaler.
// Used by the controller, the datapath and the top level.
package pwas_pkg;

   localparam int DEF_TIMER_BITS = 16;
   localparam int WORD_BITS      = 16;
   localparam int CSR_IDX_BITS   = 3;
   localparam int PROD_BITS      = 2 * WORD_BITS;
   localparam int DIV_STEPS      = PROD_BITS;
   localparam int DIV_CNT_BITS   = $clog2(DIV_STEPS);

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_BITS-1:0] REG_CLAMP_LOW  = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_CLAMP_HIGH = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_OUT_BASE   = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_OUT_SPAN   = 3'd3;

   // Reset values.
   localparam logic [WORD_BITS-1:0] RST_CLAMP_LOW  = 16'd1200;
   localparam logic [WORD_BITS-1:0] RST_CLAMP_HIGH = 16'd1800;
   localparam logic [WORD_BITS-1:0] RST_OUT_BASE   = 16'd1300;
   localparam logic [WORD_BITS-1:0] RST_OUT_SPAN   = 16'd500;
   localparam logic [WORD_BITS-1:0] RST_WIDTH_MIN  = 16'd2000;
   localparam logic [WORD_BITS-1:0] RST_WIDTH_MAX  = 16'd0;
   localparam logic [WORD_BITS-1:0] WORD_MAX       = 16'hFFFF;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic rise_load;   // store the stamp of a rising edge
      logic fall_load;   // store the stamp of a falling edge
      logic width_upd;   // form the clamped width, update min and max
      logic mult_load;   // form the numerator and the divisor
      logic div_step;    // one restoring division step
      logic out_load;    // fill the result register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic rsp_free;    // the result register can take a new word
   } sts_type;

endpackage

FILE: rtl/core/pwas_ctrl.sv
// Controller state machine of the pulse width autorange scaler.
// Depends on pwas_pkg; drives the datapath through cmd_type.
module pwas_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pwas_pkg::sts_type sts,
   output pwas_pkg::cmd_type cmd
);
   import pwas_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WIDTH,
      ST_MULT,
      ST_DIV,
      ST_DONE
   } state_type;

   state_type               state_ff, state_in;
   logic                    awaiting_fall_ff, awaiting_fall_in;
   logic [DIV_CNT_BITS-1:0] count_ff, count_in;
   logic                    accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);

   always_comb begin
      state_in         = state_ff;
      awaiting_fall_in = awaiting_fall_ff;
      count_in         = count_ff;
      cmd              = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               awaiting_fall_in = !awaiting_fall_ff;
               if (awaiting_fall_ff) begin
                  cmd.fall_load = 1'b1;
                  state_in      = ST_WIDTH;
               end else begin
                  cmd.rise_load = 1'b1;
               end
            end
         end
         ST_WIDTH: begin
            cmd.width_upd = 1'b1;
            state_in      = ST_MULT;
         end
         ST_MULT: begin
            cmd.mult_load = 1'b1;
            count_in      = '0;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            count_in     = count_ff + DIV_CNT_BITS'(1);
            if (count_ff == DIV_CNT_BITS'(DIV_STEPS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // Hold the finished word until the result register is free.
            if (sts.rsp_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         awaiting_fall_ff <= 1'b0;
         count_ff         <= '0;
      end else begin
         state_ff         <= state_in;
         awaiting_fall_ff <= awaiting_fall_in;
         count_ff         <= count_in;
      end
   end

endmodule

FILE: rtl/core/pwas_dp.sv
// Datapath of the pulse width autorange scaler: configuration registers,
// width and range tracking, multiplier, serial divider and result register.
// Depends on pwas_pkg; steered by the controller through cmd_type.
module pwas_dp #(
   parameter int TIMER_BITS = pwas_pkg::DEF_TIMER_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  pwas_pkg::cmd_type                      cmd,
   output pwas_pkg::sts_type                      sts,
   input  logic [pwas_pkg::WORD_BITS-1:0]         req_capture_time,
   input  logic                                   csr_wr_en,
   input  logic [pwas_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [pwas_pkg::WORD_BITS-1:0]         csr_wdata,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [pwas_pkg::WORD_BITS-1:0]         rsp_drive_value,
   output logic [pwas_pkg::WORD_BITS-1:0]         rsp_pulse_width,
   output logic [pwas_pkg::WORD_BITS-1:0]         rsp_seen_min,
   output logic [pwas_pkg::WORD_BITS-1:0]         rsp_seen_max
);
   import pwas_pkg::*;

   // Only the low bits of the stamp that the timer really has are used.
   localparam int STAMP_BITS = (TIMER_BITS < WORD_BITS) ? TIMER_BITS : WORD_BITS;

   logic [WORD_BITS-1:0]  clamp_low_ff, clamp_high_ff, out_base_ff, out_span_ff;
   logic [STAMP_BITS-1:0] rise_stamp_ff, rise_stamp_in;
   logic [STAMP_BITS-1:0] fall_stamp_ff, fall_stamp_in;
   logic [WORD_BITS-1:0]  held_width_ff, held_width_in;
   logic [WORD_BITS-1:0]  width_max_ff, width_max_in;
   logic [WORD_BITS-1:0]  width_min_ff, width_min_in;
   logic [PROD_BITS-1:0]  num_q_ff, num_q_in;
   logic [WORD_BITS-1:0]  den_ff, den_in;
   logic [WORD_BITS-1:0]  rem_ff, rem_in;
   logic                  flat_ff, flat_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [WORD_BITS-1:0]  drive_ff, drive_in;
   logic [WORD_BITS-1:0]  width_out_ff, width_out_in;
   logic [WORD_BITS-1:0]  min_out_ff, min_out_in;
   logic [WORD_BITS-1:0]  max_out_ff, max_out_in;

   logic [WORD_BITS-1:0]  raw_width;
   logic [WORD_BITS-1:0]  clamped;
   logic [WORD_BITS:0]    trial;
   logic [WORD_BITS:0]    trial_diff;
   logic                  qbit;
   logic [PROD_BITS:0]    drive_sum;

   // Configuration registers; indexes past the last register are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         clamp_low_ff  <= RST_CLAMP_LOW;
         clamp_high_ff <= RST_CLAMP_HIGH;
         out_base_ff   <= RST_OUT_BASE;
         out_span_ff   <= RST_OUT_SPAN;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_CLAMP_LOW:  clamp_low_ff  <= csr_wdata;
            REG_CLAMP_HIGH: clamp_high_ff <= csr_wdata;
            REG_OUT_BASE:   out_base_ff   <= csr_wdata;
            REG_OUT_SPAN:   out_span_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // A stamp that did not advance (a timer wrap included) reuses the held width.
   // Upper bound first: an inverted window gives clamp_high above it, else clamp_low.
   always_comb begin
      if (fall_stamp_ff > rise_stamp_ff) begin
         raw_width = WORD_BITS'(fall_stamp_ff - rise_stamp_ff);
      end else begin
         raw_width = held_width_ff;
      end
      if (raw_width > clamp_high_ff) begin
         clamped = clamp_high_ff;
      end else if (raw_width < clamp_low_ff) begin
         clamped = clamp_low_ff;
      end else begin
         clamped = raw_width;
      end
   end

   // Restoring division, one quotient bit per step; quotient bits shift in
   // behind the numerator bits.
   always_comb begin
      trial      = {rem_ff, num_q_ff[PROD_BITS-1]};
      trial_diff = trial - {1'b0, den_ff};
      qbit       = (trial >= {1'b0, den_ff});
   end

   assign drive_sum = {{(PROD_BITS + 1 - WORD_BITS){1'b0}}, out_base_ff}
                      + {1'b0, num_q_ff};

   always_comb begin
      rise_stamp_in = rise_stamp_ff;
      fall_stamp_in = fall_stamp_ff;
      held_width_in = held_width_ff;
      width_max_in  = width_max_ff;
      width_min_in  = width_min_ff;
      num_q_in      = num_q_ff;
      den_in        = den_ff;
      rem_in        = rem_ff;
      flat_in       = flat_ff;
      drive_in      = drive_ff;
      width_out_in  = width_out_ff;
      min_out_in    = min_out_ff;
      max_out_in    = max_out_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      if (cmd.rise_load) begin
         rise_stamp_in = req_capture_time[STAMP_BITS-1:0];
      end
      if (cmd.fall_load) begin
         fall_stamp_in = req_capture_time[STAMP_BITS-1:0];
      end
      if (cmd.width_upd) begin
         held_width_in = clamped;
         if (clamped > width_max_ff) begin
            width_max_in = clamped;
         end
         if (clamped < width_min_ff) begin
            width_min_in = clamped;
         end
      end
      if (cmd.mult_load) begin
         num_q_in = PROD_BITS'(out_span_ff) * PROD_BITS'(held_width_ff - width_min_ff);
         den_in   = width_max_ff - width_min_ff;
         flat_in  = (width_max_ff == width_min_ff);
         rem_in   = '0;
      end
      if (cmd.div_step) begin
         num_q_in = {num_q_ff[PROD_BITS-2:0], qbit};
         rem_in   = qbit ? trial_diff[WORD_BITS-1:0] : trial[WORD_BITS-1:0];
      end
      if (cmd.out_load) begin
         if (flat_ff) begin
            drive_in = out_base_ff;
         end else if (drive_sum[PROD_BITS:WORD_BITS] != '0) begin
            drive_in = WORD_MAX;
         end else begin
            drive_in = drive_sum[WORD_BITS-1:0];
         end
         width_out_in = held_width_ff;
         min_out_in   = width_min_ff;
         max_out_in   = width_max_ff;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rise_stamp_ff <= '0;
         held_width_ff <= '0;
         width_max_ff  <= RST_WIDTH_MAX;
         width_min_ff  <= RST_WIDTH_MIN;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rise_stamp_ff <= rise_stamp_in;
         held_width_ff <= held_width_in;
         width_max_ff  <= width_max_in;
         width_min_ff  <= width_min_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fall_stamp_ff <= fall_stamp_in;
      num_q_ff      <= num_q_in;
      den_ff        <= den_in;
      rem_ff        <= rem_in;
      flat_ff       <= flat_in;
      drive_ff      <= drive_in;
      width_out_ff  <= width_out_in;
      min_out_ff    <= min_out_in;
      max_out_ff    <= max_out_in;
   end

   assign sts.rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_drive_value = drive_ff;
   assign rsp_pulse_width = width_out_ff;
   assign rsp_seen_min    = min_out_ff;
   assign rsp_seen_max    = max_out_ff;

endmodule

FILE: rtl/core/pulse_width_autorange_scaler_core.sv
// Pulse width autorange scaler: turns alternating rising and falling capture
// stamps into a scaled PWM drive value. Depends on pwas_pkg, pwas_ctrl, pwas_dp.
//
// Usage:
// - The req channel takes one capture stamp per word, rising edge first, then
//   falling edge, alternating. Only the low TIMER_BITS bits, at most 16, count.
// - A rising-edge word produces nothing and does not raise req_stall.
// - A falling-edge word produces one rsp word: drive value, clamped width and
//   the smallest and largest widths seen so far.
// - A falling-edge word passes through width and range update, one multiply,
//   then 32 steps of a serial restoring divider before rsp_valid rises.
// - req_stall is high while a falling-edge word is being worked on.
// - The rsp register holds its word while rsp_stall is high; the next
//   rising-edge word is still accepted meanwhile, and a finished falling-edge
//   word waits inside until the register is free.
// - The csr port writes clamp_low, clamp_high, out_base and out_span
//   (indexes 0 to 3, others ignored); write only while the block is idle.
// - Synchronous reset restores the register defaults, clears the range
//   tracking and expects a rising edge next.
module pulse_width_autorange_scaler_core #(
   parameter int TIMER_BITS = pwas_pkg::DEF_TIMER_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [pwas_pkg::WORD_BITS-1:0]     req_capture_time,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [pwas_pkg::WORD_BITS-1:0]     rsp_drive_value,
   output logic [pwas_pkg::WORD_BITS-1:0]     rsp_pulse_width,
   output logic [pwas_pkg::WORD_BITS-1:0]     rsp_seen_min,
   output logic [pwas_pkg::WORD_BITS-1:0]     rsp_seen_max,
   input  logic                               csr_wr_en,
   input  logic [pwas_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [pwas_pkg::WORD_BITS-1:0]     csr_wdata
);
   import pwas_pkg::*;

   cmd_type cmd;
   sts_type sts;

   pwas_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   pwas_dp #(
      .TIMER_BITS (TIMER_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_capture_time (req_capture_time),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_drive_value  (rsp_drive_value),
      .rsp_pulse_width  (rsp_pulse_width),
      .rsp_seen_min     (rsp_seen_min),
      .rsp_seen_max     (rsp_seen_max)
   );

endmodule

FILE: rtl/core/pwas_checker.sv
// Port-level checker for the pulse width autorange scaler, bound to the top.
// Depends on assert_macros.svh and pwas_pkg.
`include "assert_macros.svh"

module pwas_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [pwas_pkg::WORD_BITS-1:0] rsp_drive_value,
   input logic [pwas_pkg::WORD_BITS-1:0] rsp_pulse_width,
   input logic [pwas_pkg::WORD_BITS-1:0] rsp_seen_min,
   input logic [pwas_pkg::WORD_BITS-1:0] rsp_seen_max
);
   import pwas_pkg::*;

   // A held-back word stays valid, with drive value and width unchanged.
   `PWAS_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid, "rsp word dropped while stalled")
   `PWAS_ASSERT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall |=> $stable(rsp_drive_value) && $stable(rsp_pulse_width), "rsp word changed while stalled")

   // The reported width always lies inside the reported range.
   `PWAS_ASSERT(a_width_in_range, clock, reset, rsp_valid |-> (rsp_seen_min <= rsp_pulse_width) && (rsp_pulse_width <= rsp_seen_max), "width outside seen range")

   // A new word only appears at the end of a busy period on the request side.
   `PWAS_ASSERT(a_rsp_after_work, clock, reset, $rose(rsp_valid) |-> $past(req_stall), "rsp word without preceding work")

   // Reset empties the result register.
   `PWAS_ASSERT_ALWAYS(a_reset_clears, clock, $past(reset) |-> !rsp_valid, "rsp valid right after reset")

endmodule

bind pulse_width_autorange_scaler_core pwas_checker u_pwas_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_drive_value (rsp_drive_value),
   .rsp_pulse_width (rsp_pulse_width),
   .rsp_seen_min    (rsp_seen_min),
   .rsp_seen_max    (rsp_seen_max)
);

FILE: test/pulse_width_autorange_scaler_core_test.sv
// Self-checking testbench for pulse_width_autorange_scaler_core: rising and falling capture
// stamps go in, and each drive word that comes out is checked against a predictor in the bench.
// Depends on pwas_pkg and the pulse_width_autorange_scaler_core RTL.
module pulse_width_autorange_scaler_core_test;
   import pwas_pkg::*;

   localparam int CYCLE_LIMIT = 300000;
   localparam int HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES = 40;

   typedef logic [WORD_BITS-1:0] word_t;
   typedef logic [CSR_IDX_BITS-1:0] reg_index_t;
   typedef struct packed {
      word_t drive_value;
      word_t pulse_width;
      word_t seen_min;
      word_t seen_max;
   } drive_word_t;

   class drive_checker;
      word_t clamp_low, clamp_high, out_base, out_span;
      bit awaiting_fall;
      word_t rise_stamp, held_width, width_max, width_min;
      drive_word_t expected_drives[$];
      int mismatches;

      function new();
         clamp_low = RST_CLAMP_LOW;
         clamp_high = RST_CLAMP_HIGH;
         out_base = RST_OUT_BASE;
         out_span = RST_OUT_SPAN;
         awaiting_fall = 1'b0;
         rise_stamp = '0;
         held_width = '0;
         width_max = RST_WIDTH_MAX;
         width_min = RST_WIDTH_MIN;
         mismatches = 0;
      endfunction

      function void write_reg(reg_index_t index, word_t value);
         case (index)
            REG_CLAMP_LOW: clamp_low = value;
            REG_CLAMP_HIGH: clamp_high = value;
            REG_OUT_BASE: out_base = value;
            REG_OUT_SPAN: out_span = value;
            default: ;
         endcase
      endfunction

      function void note_capture(word_t stamp);
         word_t width;
         logic [PROD_BITS-1:0] numer, denom;
         logic [WORD_BITS:0] drive;
         drive_word_t result;
         if (!awaiting_fall) begin
            rise_stamp = stamp;
            awaiting_fall = 1'b1;
            return;
         end
         awaiting_fall = 1'b0;
         // A stamp that did not move past the rising one (a wrap included) reuses the old width.
         width = (stamp > rise_stamp) ? stamp - rise_stamp : held_width;
         // When the window is inverted, the upper bound wins for widths above it, the lower one for the rest.
         if (width > clamp_high) begin
            width = clamp_high;
         end else if (width < clamp_low) begin
            width = clamp_low;
         end
         held_width = width;
         if (width > width_max) width_max = width;
         if (width < width_min) width_min = width;
         drive = {1'b0, out_base};
         if (width_max > width_min) begin
            numer = PROD_BITS'(out_span);
            numer = numer * PROD_BITS'(width - width_min);
            denom = PROD_BITS'(width_max - width_min);
            numer = numer / denom;
            drive = drive + numer[WORD_BITS:0];
         end
         result.drive_value = drive[WORD_BITS] ? WORD_MAX : drive[WORD_BITS-1:0];
         result.pulse_width = width;
         result.seen_min = width_min;
         result.seen_max = width_max;
         expected_drives.push_back(result);
      endfunction

      task report_mismatch(string msg);
         $display("mismatch: %s", msg);
         mismatches++;
      endtask

      task check_drive(drive_word_t got);
         drive_word_t want;
         if (expected_drives.size() == 0) begin
            report_mismatch($sformatf("unexpected word drive %0d width %0d min %0d max %0d",
               got.drive_value, got.pulse_width, got.seen_min, got.seen_max));
            return;
         end
         want = expected_drives.pop_front();
         if (got.drive_value !== want.drive_value)
            report_mismatch($sformatf("drive_value got %0d expected %0d",
               got.drive_value, want.drive_value));
         if (got.pulse_width !== want.pulse_width)
            report_mismatch($sformatf("pulse_width got %0d expected %0d",
               got.pulse_width, want.pulse_width));
         if (got.seen_min !== want.seen_min)
            report_mismatch($sformatf("seen_min got %0d expected %0d",
               got.seen_min, want.seen_min));
         if (got.seen_max !== want.seen_max)
            report_mismatch($sformatf("seen_max got %0d expected %0d",
               got.seen_max, want.seen_max));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;
   logic req_valid, req_stall;
   word_t req_capture_time;
   logic rsp_valid, rsp_stall;
   word_t rsp_drive_value, rsp_pulse_width, rsp_seen_min, rsp_seen_max;
   logic csr_wr_en;
   reg_index_t csr_index;
   word_t csr_wdata;

   bit idle_off = 1'b0;
   bit hold_request = 1'b0;
   int cycle_count = 0;
   drive_checker sb = new();

   pulse_width_autorange_scaler_core DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_capture_time(req_capture_time),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_drive_value(rsp_drive_value),
      .rsp_pulse_width(rsp_pulse_width),
      .rsp_seen_min(rsp_seen_min),
      .rsp_seen_max(rsp_seen_max),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("pulse_width_autorange_scaler_core_test failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_capture(req_capture_time);
         if (rsp_valid && !rsp_stall)
            sb.check_drive({rsp_drive_value, rsp_pulse_width, rsp_seen_min, rsp_seen_max});
      end
   end

   // Receiver side: short random stalls, and one long hold-off that lets the block fill up.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_stall <= 1'b0;
         end else if (!idle_off && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 7)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task send_capture(word_t stamp);
      req_capture_time <= stamp;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      if (!idle_off && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
   endtask

   task send_pair(word_t rise, word_t fall);
      send_capture(rise);
      send_capture(fall);
   endtask

   // Waits until every drive word is back, then lets a possible rising-edge word finish.
   task settle_block();
      req_valid <= 1'b0;
      while (sb.expected_drives.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task write_reg(reg_index_t index, word_t value);
      csr_index <= index;
      csr_wdata <= value;
      csr_wr_en <= 1'b1;
      @(negedge clock);
      sb.write_reg(index, value);
   endtask

   task apply_settings(word_t low, word_t high, word_t base, word_t span);
      settle_block();
      write_reg(REG_CLAMP_LOW, low);
      write_reg(REG_CLAMP_HIGH, high);
      write_reg(REG_OUT_BASE, base);
      write_reg(REG_OUT_SPAN, span);
      // Indexes past the last register must leave everything as it was.
      write_reg(reg_index_t'(REG_OUT_SPAN + 1 + $urandom_range(0, 3)), word_t'($urandom));
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      word_t low, high, base, span, rise, fall, a, b;
      int unsigned width_lo, width_hi;
      int pick, phase;
      reset = 1'b1;
      req_valid = 1'b0;
      req_capture_time = '0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: flat range first, then stamps that do not advance, wrap and extremes.
      send_pair(16'd100, 16'd1600);
      send_pair(16'd0, 16'd0);
      send_pair(WORD_MAX, 16'd10);
      send_pair(16'd0, WORD_MAX);
      send_pair(16'd5000, 16'd5001);
      send_pair(16'd200, 16'd1700);
      // Inverted window with a saturating drive.
      apply_settings(16'd3000, 16'd1000, WORD_MAX, WORD_MAX);
      send_pair(16'd10, 16'd4010);
      send_pair(16'd10, 16'd510);
      apply_settings(16'd3000, 16'd1000, 16'd60000, WORD_MAX);
      send_pair(16'd0, 16'd2000);
      send_pair(16'd0, 16'd20);
      apply_settings(16'd0, 16'd0, 16'd0, 16'd0);
      send_pair(16'd1000, 16'd1300);

      for (phase = 0; phase < 8; phase++) begin
         a = word_t'($urandom);
         b = word_t'($urandom);
         case (phase)
            0: begin
               low = RST_CLAMP_LOW; high = RST_CLAMP_HIGH;
               base = RST_OUT_BASE; span = RST_OUT_SPAN;
            end
            1: begin
               low = '0; high = WORD_MAX; base = '0; span = WORD_MAX;
            end
            3: begin
               low = (a > b) ? a : b; high = (a > b) ? b : a;
               base = word_t'($urandom); span = word_t'($urandom);
            end
            4: begin
               low = WORD_MAX; high = WORD_MAX; base = WORD_MAX; span = WORD_MAX;
            end
            5: begin
               low = a; high = b; base = word_t'($urandom); span = word_t'($urandom);
            end
            6: begin
               low = 16'd100; high = 16'd4000; base = 16'd1000; span = 16'd3000;
            end
            default: begin
               low = (a < b) ? a : b; high = (a < b) ? b : a;
               base = word_t'($urandom_range(0, 4000)); span = word_t'($urandom);
            end
         endcase
         apply_settings(low, high, base, span);
         idle_off = (phase == 7);
         if (phase == 1) hold_request = 1'b1;
         // Mostly widths around the window, some stale stamps and some random ones.
         width_lo = 32'((low < high) ? low : high);
         width_hi = 32'((low < high) ? high : low);
         width_lo = (width_lo > 256) ? width_lo - 256 : 0;
         width_hi = (width_hi < 65535 - 256) ? width_hi + 256 : 65535;
         repeat (40) begin
            rise = word_t'($urandom);
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
               fall = word_t'($urandom_range(0, rise));
            end else if (pick < 3) begin
               fall = word_t'($urandom);
            end else begin
               fall = word_t'(32'(rise) + $urandom_range(width_lo, width_hi));
            end
            send_pair(rise, fall);
         end
      end

      settle_block();
      if (sb.expected_drives.size() != 0)
         sb.report_mismatch($sformatf("%0d drive words never arrived", sb.expected_drives.size()));
      if (sb.mismatches == 0) begin
         $display("pulse_width_autorange_scaler_core_test passed");
      end else begin
         $display("pulse_width_autorange_scaler_core_test failed");
      end
      $finish;
   end
endmodule

FILE: pulse_width_autorange_scaler_core.f
+incdir+rtl/core
rtl/core/pwas_pkg.sv
rtl/core/pwas_ctrl.sv
rtl/core/pwas_dp.sv
rtl/core/pulse_width_autorange_scaler_core.sv
rtl/core/pwas_checker.sv
test/pulse_width_autorange_scaler_core_test.sv
